// ===== hw/rtl/fms_pkg.sv =====
// ----------------------------------------------------------------------------
// Folding machine sequencer package
// Phase encodings, register indexes and fixed constants of the sequencer.
// ----------------------------------------------------------------------------
package fms_pkg;

    localparam int unsigned TIMER_W       = 12;
    localparam int unsigned LEN_TIMER_W   = 24;
    localparam int unsigned DUTY_W        = 7;
    localparam int unsigned SPEED_W       = 10;
    localparam int unsigned OFFSET_W      = 12;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 12;
    localparam int unsigned LENGTH_W      = 16;
    localparam int unsigned PROD_W        = LEN_TIMER_W + SPEED_W;
    localparam int unsigned QUOT_W        = PROD_W - 8;
    localparam int unsigned IN_DATA_W     = 8;
    localparam int unsigned OUT_DATA_W    = 56;

    // Division by 1000: shift right by three, then multiply by 2^38 / 125 rounded up.
    localparam int unsigned RECIP_SHIFT   = 38;
    localparam logic [31:0] RECIP_MULT    = 32'd2199023256;

    localparam logic [DUTY_W-1:0] HOLD_DUTY      = 7'd2;
    localparam logic [DUTY_W-1:0] L1_CREEP_DUTY  = 7'd30;
    localparam logic [DUTY_W-1:0] L2_CREEP_DUTY  = 7'd20;
    localparam logic [DUTY_W-1:0] HOME_KICK_DUTY = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOADER_DUTY = 3'd0,
        REG_LAYER1_DUTY = 3'd1,
        REG_LAYER2_DUTY = 3'd2,
        REG_PLATE_DUTY  = 3'd3,
        REG_FEED_SPEED  = 3'd4,
        REG_LEN_OFFSET  = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_START = 2'd1,
        ACT_STOP  = 2'd2,
        ACT_RESET = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        LD_IDLE, LD_TO_BACK, LD_AT_BACK, LD_TO_FRONT
    } loader_phase_t;

    typedef enum logic [1:0] {
        L1_IDLE, L1_RUN, L1_CREEPING
    } layer1_phase_t;

    typedef enum logic [2:0] {
        L2_IDLE, L2_PRE, L2_FEED1, L2_PAUSE, L2_FEED2, L2_TAIL, L2_CREEPING, L2_EXIT
    } layer2_phase_t;

    typedef enum logic [1:0] {
        PL_IDLE, PL_KICK, PL_HOLD, PL_RETURN
    } plate_phase_t;

    typedef enum logic [2:0] {
        HM_IDLE, HM_L_KICK, HM_L_HOLD, HM_L_RET, HM_R_KICK, HM_R_HOLD, HM_R_RET, HM_LOADER
    } homing_phase_t;

    function automatic logic [TIMER_W-1:0] tick_down(input logic [TIMER_W-1:0] value);
        tick_down = (value != '0) ? value - 1'b1 : value;
    endfunction

    function automatic logic [DUTY_W-1:0] plate_drive(input plate_phase_t phase,
                                                      input logic [DUTY_W-1:0] kick);
        case (phase)
            PL_KICK:             plate_drive = kick;
            PL_HOLD, PL_RETURN:  plate_drive = HOLD_DUTY;
            default:             plate_drive = '0;
        endcase
    endfunction

endpackage

// ===== hw/rtl/folding_machine_sequencer.sv =====
// ----------------------------------------------------------------------------
// Folding machine sequencer
// Loader, conveyor, fold plate, length and homing sequencers, one tick a transfer.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_axis    in         one sensor snapshot and button action per tick
// m_axis    out        motor duties, fold count, homing flag, garment length
// cfg       in         register writes, taken at once
//
// A transfer is accepted in every cycle while the output stage is free or taken.
// Each result is registered in the input stage, then in the sequencer update with
// the length product, the reciprocal multiply for the division by 1000, and the
// offset and saturation. A stall on m_axis holds the whole pipeline. Reset clears
// all sequencers and timers to idle and the config registers to their defaults.
// ----------------------------------------------------------------------------
module folding_machine_sequencer #(
    parameter int unsigned KICK_TICKS        = 130,
    parameter int unsigned LEFT_HOLD_TICKS   = 80,
    parameter int unsigned RIGHT_HOLD_TICKS  = 70,
    parameter int unsigned LAYER_DELAY_TICKS = 600,
    parameter int unsigned EXIT_DELAY_TICKS  = 2000
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // action, loader_front_hall, loader_rear_hall, plate_left_hall,
    // plate_right_hall, cloth_front, cloth_rear
    input  logic [fms_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // loader_drive, loader_direction, layer1_drive, layer2_drive,
    // plate_left_drive, plate_right_drive, fold_count, reset_busy,
    // garment_length, length_valid
    output logic [fms_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              cfg_wr_en,
    input  logic [fms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fms_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    localparam int unsigned TW = fms_pkg::TIMER_W;
    localparam int unsigned LW = fms_pkg::LEN_TIMER_W;
    localparam int unsigned DW = fms_pkg::DUTY_W;

    logic enable;

    logic [DW-1:0]                   loader_duty_reg, layer1_duty_reg, layer2_duty_reg;
    logic [DW-1:0]                   plate_duty_reg;
    logic [fms_pkg::SPEED_W-1:0]     feed_speed_reg;
    logic [fms_pkg::OFFSET_W-1:0]    length_offset_reg;

    logic                            s0_valid_reg;
    logic [fms_pkg::IN_DATA_W-1:0]   s0_data_reg;

    fms_pkg::loader_phase_t  loader_phase_reg, loader_phase_next;
    fms_pkg::layer1_phase_t  layer1_phase_reg, layer1_phase_next;
    fms_pkg::layer2_phase_t  layer2_phase_reg, layer2_phase_next;
    fms_pkg::plate_phase_t   plate_left_reg, plate_left_next;
    fms_pkg::plate_phase_t   plate_right_reg, plate_right_next;
    fms_pkg::homing_phase_t  homing_phase_reg, homing_phase_next;
    logic [1:0]              plates_returned_reg, plates_returned_next;
    logic [1:0]              fold_strokes_reg, fold_strokes_next;
    logic                    machine_ready_reg, machine_ready_next;
    logic                    length_phase_reg, length_phase_next;
    logic [LW-1:0]           length_ticks_reg, length_ticks_next;
    logic [TW-1:0]           timer_reg [4];
    logic [TW-1:0]           timer_next [4];

    logic [DW-1:0]           ld_drive, l1_drive, l2_drive, pl_drive, pr_drive;
    logic                    ld_dir, len_done;
    logic [LW-1:0]           len_ticks;

    logic                          s1_valid_reg, s2_valid_reg, out_valid_reg;
    logic [38:0]                   s1_out_reg, s2_out_reg;
    logic                          s1_len_reg, s2_len_reg;
    logic [fms_pkg::PROD_W-1:0]    s1_prod_reg;
    logic [fms_pkg::QUOT_W-1:0]    s2_quot_reg;
    logic [63:0]                   recip_prod;
    logic [fms_pkg::QUOT_W:0]      len_sum;
    logic [fms_pkg::LENGTH_W-1:0]  len_sat;
    logic [fms_pkg::LENGTH_W-1:0]  last_length_reg;
    logic [fms_pkg::OUT_DATA_W-1:0] out_data_reg;

    assign enable        = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = enable;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        logic [1:0]    action;
        logic          fhall, rhall, lhall, rthall, fphoto, rphoto;
        logic [TW-1:0] d;

        d      = '0;
        action = s0_data_reg[1:0];
        fhall  = s0_data_reg[2];
        rhall  = s0_data_reg[3];
        lhall  = s0_data_reg[4];
        rthall = s0_data_reg[5];
        fphoto = s0_data_reg[6];
        rphoto = s0_data_reg[7];

        loader_phase_next    = loader_phase_reg;
        layer1_phase_next    = layer1_phase_reg;
        layer2_phase_next    = layer2_phase_reg;
        plate_left_next      = plate_left_reg;
        plate_right_next     = plate_right_reg;
        homing_phase_next    = homing_phase_reg;
        plates_returned_next = plates_returned_reg;
        fold_strokes_next    = fold_strokes_reg;
        machine_ready_next   = machine_ready_reg;
        length_phase_next    = length_phase_reg;
        length_ticks_next    = length_ticks_reg;
        for (int i = 0; i < 4; i++)
        begin
            timer_next[i] = timer_reg[i];
        end
        len_done = 1'b0;

        case (homing_phase_next)
            fms_pkg::HM_L_KICK:
            begin
                d = fms_pkg::tick_down(timer_next[3]);
                timer_next[3] = d;
                if (d == '0)
                begin
                    homing_phase_next = fms_pkg::HM_L_HOLD;
                    timer_next[3] = TW'(LEFT_HOLD_TICKS);
                end
            end
            fms_pkg::HM_L_HOLD:
            begin
                d = fms_pkg::tick_down(timer_next[3]);
                timer_next[3] = d;
                if (d == '0)
                begin
                    homing_phase_next = fms_pkg::HM_L_RET;
                end
            end
            fms_pkg::HM_L_RET:
            begin
                if (!lhall)
                begin
                    homing_phase_next = fms_pkg::HM_R_KICK;
                    timer_next[3] = TW'(KICK_TICKS);
                end
            end
            fms_pkg::HM_R_KICK:
            begin
                d = fms_pkg::tick_down(timer_next[3]);
                timer_next[3] = d;
                if (d == '0)
                begin
                    homing_phase_next = fms_pkg::HM_R_HOLD;
                    timer_next[3] = TW'(RIGHT_HOLD_TICKS);
                end
            end
            fms_pkg::HM_R_HOLD:
            begin
                d = fms_pkg::tick_down(timer_next[3]);
                timer_next[3] = d;
                if (d == '0)
                begin
                    homing_phase_next = fms_pkg::HM_R_RET;
                end
            end
            fms_pkg::HM_R_RET:
            begin
                if (!rthall)
                begin
                    homing_phase_next = fms_pkg::HM_LOADER;
                end
            end
            fms_pkg::HM_LOADER:
            begin
                if (!fhall)
                begin
                    loader_phase_next  = fms_pkg::LD_IDLE;
                    homing_phase_next  = fms_pkg::HM_IDLE;
                    machine_ready_next = 1'b1;
                end
            end
            default:
            begin
                homing_phase_next = fms_pkg::HM_IDLE;
            end
        endcase

        case (plate_left_next)
            fms_pkg::PL_KICK:
            begin
                d = fms_pkg::tick_down(timer_next[1]);
                timer_next[1] = d;
                if (d == '0)
                begin
                    plate_left_next = fms_pkg::PL_HOLD;
                    timer_next[1] = TW'(LEFT_HOLD_TICKS);
                end
            end
            fms_pkg::PL_HOLD:
            begin
                d = fms_pkg::tick_down(timer_next[1]);
                timer_next[1] = d;
                if (d == '0)
                begin
                    plate_left_next = fms_pkg::PL_RETURN;
                end
            end
            fms_pkg::PL_RETURN:
            begin
                if (!lhall)
                begin
                    if (plates_returned_next != 2'd3)
                    begin
                        plates_returned_next = plates_returned_next + 2'd1;
                    end
                    plate_left_next = fms_pkg::PL_IDLE;
                end
            end
            default:
            begin
                plate_left_next = fms_pkg::PL_IDLE;
            end
        endcase

        case (plate_right_next)
            fms_pkg::PL_KICK:
            begin
                d = fms_pkg::tick_down(timer_next[2]);
                timer_next[2] = d;
                if (d == '0)
                begin
                    plate_right_next = fms_pkg::PL_HOLD;
                    timer_next[2] = TW'(RIGHT_HOLD_TICKS);
                end
            end
            fms_pkg::PL_HOLD:
            begin
                d = fms_pkg::tick_down(timer_next[2]);
                timer_next[2] = d;
                if (d == '0)
                begin
                    plate_right_next = fms_pkg::PL_RETURN;
                end
            end
            fms_pkg::PL_RETURN:
            begin
                if (!rthall)
                begin
                    if (plates_returned_next != 2'd3)
                    begin
                        plates_returned_next = plates_returned_next + 2'd1;
                    end
                    plate_right_next = fms_pkg::PL_IDLE;
                end
            end
            default:
            begin
                plate_right_next = fms_pkg::PL_IDLE;
            end
        endcase

        if (length_phase_next)
        begin
            if (length_ticks_next != '1)
            begin
                length_ticks_next = length_ticks_next + 1'b1;
            end
            if (rphoto)
            begin
                len_done          = 1'b1;
                length_phase_next = 1'b0;
            end
        end
        len_ticks = length_ticks_next;

        case (layer2_phase_next)
            fms_pkg::L2_IDLE:
            begin
                if (layer1_phase_next == fms_pkg::L1_RUN)
                begin
                    layer2_phase_next = fms_pkg::L2_PRE;
                    timer_next[0] = TW'(LAYER_DELAY_TICKS);
                end
            end
            fms_pkg::L2_PRE:
            begin
                d = fms_pkg::tick_down(timer_next[0]);
                timer_next[0] = d;
                if (d == '0)
                begin
                    layer2_phase_next = fms_pkg::L2_FEED1;
                end
            end
            fms_pkg::L2_FEED1:
            begin
                if (fphoto)
                begin
                    plate_left_next   = fms_pkg::PL_KICK;
                    plate_right_next  = fms_pkg::PL_KICK;
                    timer_next[1]     = TW'(KICK_TICKS);
                    timer_next[2]     = TW'(KICK_TICKS);
                    layer2_phase_next = fms_pkg::L2_PAUSE;
                    fold_strokes_next = 2'd1;
                end
            end
            fms_pkg::L2_PAUSE:
            begin
                if (plates_returned_next >= 2'd2)
                begin
                    plates_returned_next = 2'd0;
                    if (fold_strokes_next == 2'd1)
                    begin
                        length_phase_next = 1'b1;
                        length_ticks_next = '0;
                        layer2_phase_next = fms_pkg::L2_FEED2;
                    end
                    else if (fold_strokes_next == 2'd2)
                    begin
                        layer2_phase_next = fms_pkg::L2_CREEPING;
                    end
                    else
                    begin
                        layer2_phase_next = fms_pkg::L2_IDLE;
                    end
                end
            end
            fms_pkg::L2_FEED2:
            begin
                if (rphoto)
                begin
                    layer2_phase_next = fms_pkg::L2_TAIL;
                    timer_next[0] = TW'(LAYER_DELAY_TICKS);
                end
            end
            fms_pkg::L2_TAIL:
            begin
                d = fms_pkg::tick_down(timer_next[0]);
                timer_next[0] = d;
                if (d == '0)
                begin
                    plate_left_next   = fms_pkg::PL_KICK;
                    plate_right_next  = fms_pkg::PL_KICK;
                    timer_next[1]     = TW'(KICK_TICKS);
                    timer_next[2]     = TW'(KICK_TICKS);
                    layer2_phase_next = fms_pkg::L2_PAUSE;
                    fold_strokes_next = 2'd2;
                end
            end
            fms_pkg::L2_CREEPING:
            begin
                if (!fphoto)
                begin
                    layer2_phase_next = fms_pkg::L2_EXIT;
                    timer_next[0] = TW'(EXIT_DELAY_TICKS);
                end
            end
            default:
            begin
                d = fms_pkg::tick_down(timer_next[0]);
                timer_next[0] = d;
                if (d == '0)
                begin
                    layer2_phase_next = fms_pkg::L2_IDLE;
                    fold_strokes_next = 2'd0;
                end
            end
        endcase

        case (layer1_phase_next)
            fms_pkg::L1_IDLE:
            begin
                if (!rhall && machine_ready_next && loader_phase_next == fms_pkg::LD_AT_BACK)
                begin
                    layer1_phase_next  = fms_pkg::L1_RUN;
                    machine_ready_next = 1'b0;
                end
            end
            fms_pkg::L1_RUN:
            begin
                if (!rphoto)
                begin
                    layer1_phase_next = fms_pkg::L1_CREEPING;
                end
            end
            fms_pkg::L1_CREEPING:
            begin
                if (fold_strokes_next == 2'd2)
                begin
                    layer1_phase_next = fms_pkg::L1_IDLE;
                end
            end
            default:
            begin
                layer1_phase_next = fms_pkg::L1_IDLE;
            end
        endcase

        case (loader_phase_next)
            fms_pkg::LD_TO_BACK:
            begin
                if (!rhall)
                begin
                    loader_phase_next = fms_pkg::LD_AT_BACK;
                end
            end
            fms_pkg::LD_AT_BACK:
            begin
                if (fphoto)
                begin
                    loader_phase_next = fms_pkg::LD_TO_FRONT;
                end
            end
            fms_pkg::LD_TO_FRONT:
            begin
                if (!fhall)
                begin
                    loader_phase_next  = fms_pkg::LD_IDLE;
                    machine_ready_next = 1'b1;
                end
            end
            default:
            begin
                loader_phase_next = fms_pkg::LD_IDLE;
            end
        endcase

        case (action)
            fms_pkg::ACT_START:
            begin
                if (machine_ready_next && loader_phase_next == fms_pkg::LD_IDLE)
                begin
                    loader_phase_next = fms_pkg::LD_TO_BACK;
                end
            end
            fms_pkg::ACT_STOP:
            begin
                loader_phase_next    = fms_pkg::LD_IDLE;
                layer1_phase_next    = fms_pkg::L1_IDLE;
                layer2_phase_next    = fms_pkg::L2_IDLE;
                plate_left_next      = fms_pkg::PL_IDLE;
                plate_right_next     = fms_pkg::PL_IDLE;
                plates_returned_next = 2'd0;
                fold_strokes_next    = 2'd0;
                machine_ready_next   = 1'b0;
                length_phase_next    = 1'b0;
                length_ticks_next    = '0;
                homing_phase_next    = fms_pkg::HM_IDLE;
                for (int i = 0; i < 4; i++)
                begin
                    timer_next[i] = '0;
                end
            end
            fms_pkg::ACT_RESET:
            begin
                homing_phase_next = fms_pkg::HM_L_KICK;
                timer_next[3]     = TW'(KICK_TICKS);
            end
            default:
            begin
            end
        endcase

        ld_drive = (loader_phase_next == fms_pkg::LD_TO_BACK ||
                    loader_phase_next == fms_pkg::LD_TO_FRONT) ? loader_duty_reg : '0;
        ld_dir   = !(loader_phase_next == fms_pkg::LD_TO_BACK ||
                     loader_phase_next == fms_pkg::LD_AT_BACK);
        if (homing_phase_next == fms_pkg::HM_LOADER)
        begin
            ld_drive = fhall ? loader_duty_reg : '0;
            ld_dir   = 1'b1;
        end

        case (layer1_phase_next)
            fms_pkg::L1_RUN:      l1_drive = layer1_duty_reg;
            fms_pkg::L1_CREEPING: l1_drive = fms_pkg::L1_CREEP_DUTY;
            default:              l1_drive = '0;
        endcase

        case (layer2_phase_next)
            fms_pkg::L2_FEED1, fms_pkg::L2_FEED2, fms_pkg::L2_TAIL:
                l2_drive = layer2_duty_reg;
            fms_pkg::L2_CREEPING, fms_pkg::L2_EXIT:
                l2_drive = fms_pkg::L2_CREEP_DUTY;
            default:
                l2_drive = '0;
        endcase

        pl_drive = fms_pkg::plate_drive(plate_left_next, plate_duty_reg);
        pr_drive = fms_pkg::plate_drive(plate_right_next, plate_duty_reg);
        if (homing_phase_next == fms_pkg::HM_L_KICK)
        begin
            pl_drive = fms_pkg::HOME_KICK_DUTY;
        end
        else if (homing_phase_next == fms_pkg::HM_L_HOLD ||
                 homing_phase_next == fms_pkg::HM_L_RET)
        begin
            pl_drive = fms_pkg::HOLD_DUTY;
        end
        if (homing_phase_next == fms_pkg::HM_R_KICK)
        begin
            pr_drive = fms_pkg::HOME_KICK_DUTY;
        end
        else if (homing_phase_next == fms_pkg::HM_R_HOLD ||
                 homing_phase_next == fms_pkg::HM_R_RET)
        begin
            pr_drive = fms_pkg::HOLD_DUTY;
        end
    end

    assign recip_prod = 64'(s1_prod_reg[fms_pkg::PROD_W-1:3]) * 64'(fms_pkg::RECIP_MULT);
    assign len_sum    = (fms_pkg::QUOT_W+1)'(s2_quot_reg) +
                        (fms_pkg::QUOT_W+1)'(length_offset_reg);
    assign len_sat    = (len_sum > (fms_pkg::QUOT_W+1)'(16'hFFFF)) ? 16'hFFFF
                                                                  : len_sum[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loader_duty_reg   <= 7'd70;
            layer1_duty_reg   <= 7'd100;
            layer2_duty_reg   <= 7'd100;
            plate_duty_reg    <= 7'd100;
            feed_speed_reg    <= 10'd250;
            length_offset_reg <= 12'd450;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                fms_pkg::REG_LOADER_DUTY: loader_duty_reg   <= cfg_wr_data[DW-1:0];
                fms_pkg::REG_LAYER1_DUTY: layer1_duty_reg   <= cfg_wr_data[DW-1:0];
                fms_pkg::REG_LAYER2_DUTY: layer2_duty_reg   <= cfg_wr_data[DW-1:0];
                fms_pkg::REG_PLATE_DUTY:  plate_duty_reg    <= cfg_wr_data[DW-1:0];
                fms_pkg::REG_FEED_SPEED:  feed_speed_reg    <= cfg_wr_data[9:0];
                fms_pkg::REG_LEN_OFFSET:  length_offset_reg <= cfg_wr_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg        <= 1'b0;
            s1_valid_reg        <= 1'b0;
            s2_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            loader_phase_reg    <= fms_pkg::LD_IDLE;
            layer1_phase_reg    <= fms_pkg::L1_IDLE;
            layer2_phase_reg    <= fms_pkg::L2_IDLE;
            plate_left_reg      <= fms_pkg::PL_IDLE;
            plate_right_reg     <= fms_pkg::PL_IDLE;
            homing_phase_reg    <= fms_pkg::HM_IDLE;
            plates_returned_reg <= 2'd0;
            fold_strokes_reg    <= 2'd0;
            machine_ready_reg   <= 1'b0;
            length_phase_reg    <= 1'b0;
            length_ticks_reg    <= '0;
            last_length_reg     <= '0;
            for (int i = 0; i < 4; i++)
            begin
                timer_reg[i] <= '0;
            end
        end
        else if (enable)
        begin
            s0_valid_reg  <= s_axis_tvalid;
            s1_valid_reg  <= s0_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s0_valid_reg)
            begin
                loader_phase_reg    <= loader_phase_next;
                layer1_phase_reg    <= layer1_phase_next;
                layer2_phase_reg    <= layer2_phase_next;
                plate_left_reg      <= plate_left_next;
                plate_right_reg     <= plate_right_next;
                homing_phase_reg    <= homing_phase_next;
                plates_returned_reg <= plates_returned_next;
                fold_strokes_reg    <= fold_strokes_next;
                machine_ready_reg   <= machine_ready_next;
                length_phase_reg    <= length_phase_next;
                length_ticks_reg    <= length_ticks_next;
                for (int i = 0; i < 4; i++)
                begin
                    timer_reg[i] <= timer_next[i];
                end
            end
            if (s2_valid_reg && s2_len_reg)
            begin
                last_length_reg <= len_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            s0_data_reg <= s_axis_tdata;
            s1_out_reg  <= {homing_phase_next != fms_pkg::HM_IDLE, fold_strokes_next,
                            pr_drive, pl_drive, l2_drive, l1_drive, ld_dir, ld_drive};
            s1_len_reg  <= len_done;
            s1_prod_reg <= fms_pkg::PROD_W'(len_ticks) *
                           fms_pkg::PROD_W'(feed_speed_reg);
            s2_out_reg  <= s1_out_reg;
            s2_len_reg  <= s1_len_reg;
            s2_quot_reg <= recip_prod[fms_pkg::RECIP_SHIFT +: fms_pkg::QUOT_W];
            out_data_reg <= {s2_len_reg, (s2_len_reg ? len_sat : last_length_reg),
                             s2_out_reg};
        end
    end

endmodule
